[rtl/mdv_pkg.sv]
// shared types and constants for the motion direction vote core
// field widths, direction and register codes, controller/datapath command and status
// no dependencies
package mdv_pkg;

   localparam int MAX_PIXELS  = 4096;
   localparam int ANGLE_W     = 9;
   localparam int ROW_W       = 10;
   localparam int THRESH_W    = 16;
   localparam int VOTE_W      = 16;
   localparam int DIR_W       = 2;
   localparam int ANGLE_MAX   = (1 << ANGLE_W) - 1;
   localparam int CNT_W       = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W       = $clog2(MAX_PIXELS * ANGLE_MAX + 1);
   // quotient never exceeds the largest angle
   localparam int QUOT_W      = ANGLE_W;
   localparam int STEP_W      = $clog2(QUOT_W);
   localparam int TRIAL_W     = CNT_W + QUOT_W - 1;

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam int REQ_FIELD_W = ANGLE_W + ROW_W;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = ANGLE_W + DIR_W + 1 + VOTE_W + VOTE_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [ANGLE_W-1:0]  ANG_FOLD_LO   = ANGLE_W'(271);
   localparam logic [ANGLE_W-1:0]  ANG_FULL      = ANGLE_W'(360);
   localparam logic [QUOT_W-1:0]   AVG_HOLD_LO   = QUOT_W'(90);
   localparam logic [QUOT_W-1:0]   AVG_HOLD_HI   = QUOT_W'(91);
   localparam logic [QUOT_W-1:0]   AVG_MAX       = QUOT_W'(270);
   localparam logic [ROW_W-1:0]    FIRST_ROW_RST = ROW_W'(15);
   localparam logic [THRESH_W-1:0] THRESH_RST    = THRESH_W'(50);
   localparam logic [VOTE_W-1:0]   VOTE_SAT      = {VOTE_W{1'b1}};
   localparam logic [STEP_W-1:0]   DIV_TOP_STEP  = STEP_W'(QUOT_W - 1);

   typedef enum logic [DIR_W-1:0] {
      DIR_NONE  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_LEFT  = 2'd2
   } dir_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_ROW = 1'b0,
      CSR_THRESHOLD = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic              pix_en;    // pixel beat accepted
      logic              div_step;  // one quotient bit
      logic [STEP_W-1:0] shift;     // weight of that bit
      logic              finish;    // classify and load result
   } mdv_cmd_type;

   typedef struct packed {
      logic out_busy;               // result register cannot take a new beat
   } mdv_status_type;

endpackage

[rtl/motion_direction_vote_core.sv]
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata: angle[8:0] row[18:9]; tlast: frame_end
// rsp_      out  rsp_tvalid/rsp_tready  tdata: average_angle, direction, confirmed_right,
//                                       right_votes, left_votes
// csr_      in   csr_valid/csr_ready    index 0 first_row, 1 confirm_threshold
//
// pixels are taken one per cycle while intake is open; a frame-end pixel closes intake
// for the bit-serial divide and the result load, and intake reopens after the load
// the load waits while the result register still holds an untaken beat
// reset is synchronous; no clearing pass, intake opens the cycle after reset
// configuration writes are always taken
// top level of the motion direction vote core, joins mdv_ctrl and mdv_datapath
// depends on mdv_pkg, mdv_ctrl, mdv_datapath
module motion_direction_vote_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mdv_pkg::REQ_DATA_W-1:0]    req_tdata,   // angle, row, zero pad
   input  logic                              req_tlast,   // frame_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // average_angle, direction, confirmed_right, right_votes, left_votes, zero pad
   output logic [mdv_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mdv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mdv_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mdv_pkg::*;

   mdv_cmd_type    cmd;
   mdv_status_type status;
   logic [ANGLE_W-1:0] angle;
   logic [ROW_W-1:0]   row;

   assign angle     = req_tdata[ANGLE_W-1:0];
   assign row       = req_tdata[ANGLE_W+ROW_W-1:ANGLE_W];
   assign csr_ready = 1'b1;

   mdv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   mdv_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .angle      (angle),
      .row        (row),
      .csr_valid  (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/mdv_ctrl.sv]
// controller for the motion direction vote core
// sequences pixel intake, the bit-serial divide and the result load
// depends on mdv_pkg
module mdv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_tlast,
   input  mdv_pkg::mdv_status_type status,
   output mdv_pkg::mdv_cmd_type    cmd
);
   import mdv_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.pix_en   = 1'b0;
      cmd.div_step = 1'b0;
      cmd.shift    = step_ff;
      cmd.finish   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.pix_en = accept;
            if (accept && req_tlast) begin
               state_in = ST_DIV;
               step_in  = DIV_TOP_STEP;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

`ifndef SYNTHESIS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= DIV_TOP_STEP)
      else $error("divide step out of range");

   a_div_follows_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> state_ff == ST_DIV && step_ff == DIV_TOP_STEP)
      else $error("frame end did not start the divide");

   a_finish_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> req_tready)
      else $error("intake not reopened after result load");
`endif

endmodule

[rtl/mdv_datapath.sv]
// datapath for the motion direction vote core
// angle accumulator, restoring divider on the sum, vote counters, result register
// depends on mdv_pkg
module mdv_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mdv_pkg::mdv_cmd_type              cmd,
   output mdv_pkg::mdv_status_type           status,
   input  logic [mdv_pkg::ANGLE_W-1:0]       angle,
   input  logic [mdv_pkg::ROW_W-1:0]         row,
   input  logic                              csr_valid,
   input  logic [mdv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mdv_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mdv_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import mdv_pkg::*;

   logic [ROW_W-1:0]    first_row_ff;
   logic [THRESH_W-1:0] thresh_ff;

   // sum doubles as the divider remainder after frame end
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;

   dir_type             last_dir_ff, last_dir_in;
   logic [VOTE_W-1:0]   right_ff, right_in;
   logic [VOTE_W-1:0]   left_ff, left_in;
   logic                latched_ff, latched_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [QUOT_W-1:0]   out_avg_ff;
   dir_type             out_dir_ff;
   logic                out_latched_ff;
   logic [VOTE_W-1:0]   out_right_ff;
   logic [VOTE_W-1:0]   out_left_ff;

   logic [ANGLE_W-1:0]  folded;
   logic                take_pixel;
   logic [TRIAL_W-1:0]  trial;
   logic [TRIAL_W-1:0]  rem_ext;
   logic                fits;
   logic [QUOT_W-1:0]   avg;
   logic                has_pixels;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_row_ff <= FIRST_ROW_RST;
         thresh_ff    <= THRESH_RST;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FIRST_ROW: first_row_ff <= csr_data[ROW_W-1:0];
            CSR_THRESHOLD: thresh_ff    <= csr_data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // pixel filter and fold
   assign folded = (angle >= ANG_FOLD_LO && angle <= ANG_FULL) ? ANG_FULL - angle : angle;
   assign take_pixel = (angle != '0) && (row >= first_row_ff)
                       && (count_ff < CNT_W'(MAX_PIXELS));

   // one restoring divide step per cycle, most significant quotient bit first
   assign trial   = TRIAL_W'(count_ff) << cmd.shift;
   assign rem_ext = TRIAL_W'(sum_ff);
   assign fits    = rem_ext >= trial;

   assign has_pixels = (count_ff != '0);
   assign avg        = has_pixels ? quot_ff : '0;

   always_comb begin
      sum_in      = sum_ff;
      count_in    = count_ff;
      quot_in     = quot_ff;
      last_dir_in = last_dir_ff;
      right_in    = right_ff;
      left_in     = left_ff;
      latched_in  = latched_ff;
      if (cmd.pix_en && take_pixel) begin
         sum_in   = sum_ff + SUM_W'(folded);
         count_in = count_ff + 1'b1;
      end
      if (cmd.div_step) begin
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         if (fits) begin
            sum_in = SUM_W'(rem_ext - trial);
         end
      end
      if (cmd.finish) begin
         sum_in   = '0;
         count_in = '0;
         priority if (!has_pixels || avg == '0 || avg > AVG_MAX) begin
            last_dir_in = DIR_NONE;
         end else if (avg < AVG_HOLD_LO) begin
            last_dir_in = DIR_RIGHT;
            if (right_ff != VOTE_SAT) right_in = right_ff + 1'b1;
         end else if (avg > AVG_HOLD_HI) begin
            last_dir_in = DIR_LEFT;
            if (!latched_ff) begin
               right_in = '0;
            end else if (left_ff != VOTE_SAT) begin
               left_in = left_ff + 1'b1;
            end
         end else begin
            last_dir_in = last_dir_ff;
         end
         if (right_in > thresh_ff) latched_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         count_ff    <= '0;
         last_dir_ff <= DIR_NONE;
         right_ff    <= '0;
         left_ff     <= '0;
         latched_ff  <= 1'b0;
      end else begin
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         last_dir_ff <= last_dir_in;
         right_ff    <= right_in;
         left_ff     <= left_in;
         latched_ff  <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   // result register
   assign status.out_busy = rsp_valid_ff & ~rsp_tready;
   assign rsp_valid_in    = cmd.finish | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_avg_ff     <= avg;
         out_dir_ff     <= last_dir_in;
         out_latched_ff <= latched_in;
         out_right_ff   <= right_in;
         out_left_ff    <= left_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_left_ff, out_right_ff, out_latched_ff,
                                    out_dir_ff, out_avg_ff});

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PIXELS))
      else $error("pixel count past limit");

   a_latch_sticky: assert property (@(posedge clock) disable iff (reset)
      latched_ff |=> latched_ff)
      else $error("confirmed right flag dropped");

   a_left_needs_latch: assert property (@(posedge clock) disable iff (reset)
      left_ff != '0 |-> latched_ff)
      else $error("left votes counted before confirmation");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> sum_ff == '0 && count_ff == '0)
      else $error("accumulators not cleared at frame end");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> out_dir_ff != dir_type'(2'd3))
      else $error("bad direction code in result");
`endif

endmodule

[tb/sv/motion_direction_vote_core_tb.sv]
// self-checking testbench for motion_direction_vote_core: directed frames, random frames,
// output back-pressure and the right-vote latch
// depends on mdv_pkg and the motion_direction_vote_core rtl
module motion_direction_vote_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mdv_pkg::*;

   // bit positions inside rsp_tdata
   localparam int DIR_LSB  = ANGLE_W;
   localparam int CONF_BIT = DIR_LSB + DIR_W;
   localparam int RV_LSB   = CONF_BIT + 1;
   localparam int LV_LSB   = RV_LSB + VOTE_W;

   typedef struct {
      logic [ANGLE_W-1:0] average;
      dir_type            direction;
      logic               confirmed;
      logic [VOTE_W-1:0]  right_votes;
      logic [VOTE_W-1:0]  left_votes;
   } vote_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // angle, row, zero pad
   logic                  req_tlast = 1'b0; // frame_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // average_angle, direction, confirmed_right, right_votes, left_votes, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FIRST_ROW;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predicted block state
   logic [ROW_W-1:0]      cfg_first_row = FIRST_ROW_RST;
   logic [THRESH_W-1:0]   cfg_threshold = THRESH_RST;
   logic [SUM_W-1:0]      ang_sum = '0;
   logic [CNT_W-1:0]      pix_count = '0;
   dir_type               held_dir = DIR_NONE;
   logic [VOTE_W-1:0]     right_tally = '0;
   logic [VOTE_W-1:0]     left_tally = '0;
   logic                  right_confirmed = 1'b0;

   vote_type              expected_votes[$];
   int                    mismatch_count = 0;
   bit                    src_idle = 1'b0;
   logic                  sink_idle = 1'b0;
   logic                  hold_rsp = 1'b0;
   int                    sink_gap = 0;

   motion_direction_vote_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // accumulate one accepted pixel; on frame end classify and queue the vote
   function automatic void tally_pixel(logic [ANGLE_W-1:0] angle, logic [ROW_W-1:0] row,
                                       logic fend);
      logic [ANGLE_W-1:0] folded;
      logic [SUM_W-1:0]   quot;
      vote_type           v;
      folded = angle;
      if (angle >= ANG_FOLD_LO && angle <= ANG_FULL) begin
         folded = ANG_FULL - angle;
      end
      if (angle != 0 && row >= cfg_first_row && pix_count < MAX_PIXELS) begin
         ang_sum   += SUM_W'(folded);
         pix_count += 1'b1;
      end
      if (!fend) return;
      quot = '0;
      if (pix_count != 0) begin
         quot = ang_sum / SUM_W'(pix_count);
      end
      if (quot != 0 && quot <= AVG_MAX) begin
         if (quot < AVG_HOLD_LO) begin
            held_dir = DIR_RIGHT;
            if (right_tally != VOTE_SAT) right_tally++;
         end else if (quot > AVG_HOLD_HI) begin
            held_dir = DIR_LEFT;
            if (!right_confirmed) right_tally = '0;
            else if (left_tally != VOTE_SAT) left_tally++;
         end
      end else begin
         held_dir = DIR_NONE;
      end
      if (right_tally > cfg_threshold) right_confirmed = 1'b1;
      v.average     = quot[ANGLE_W-1:0];
      v.direction   = held_dir;
      v.confirmed   = right_confirmed;
      v.right_votes = right_tally;
      v.left_votes  = left_tally;
      expected_votes.push_back(v);
      ang_sum   = '0;
      pix_count = '0;
   endfunction

   function automatic void check_field(string name, logic [VOTE_W-1:0] want,
                                       logic [VOTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_vote(logic [RSP_DATA_W-1:0] beat);
      vote_type want;
      if (expected_votes.size() == 0) begin
         $error("result beat with no vote expected: %h", beat);
         mismatch_count++;
         return;
      end
      want = expected_votes.pop_front();
      check_field("average_angle", want.average, beat[ANGLE_W-1:0]);
      check_field("direction", want.direction, beat[DIR_LSB +: DIR_W]);
      check_field("confirmed_right", want.confirmed, beat[CONF_BIT]);
      check_field("right_votes", want.right_votes, beat[RV_LSB +: VOTE_W]);
      check_field("left_votes", want.left_votes, beat[LV_LSB +: VOTE_W]);
   endfunction

   // result sink: checks every beat, stalls in random bursts or while held off
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) check_vote(rsp_tdata);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap   <= sink_gap - 1;
         rsp_tready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 9) == 0) begin
         sink_gap   <= $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_rsp;
      end
   end

   task automatic set_idling(bit on);
      src_idle = on;
      sink_idle <= on;
   endtask

   task automatic send_pixel(int angle, int row, bit fend);
      if (src_idle && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({row[ROW_W-1:0], angle[ANGLE_W-1:0]});
      req_tlast  <= fend;
      do @(posedge clock); while (!req_tready);
      tally_pixel(angle[ANGLE_W-1:0], row[ROW_W-1:0], fend);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_votes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // writes both registers back to back; junk above the first_row width
   task automatic load_config(int first_row, int threshold);
      logic [CSR_DATA_W-1:0] row_word;
      row_word = CSR_DATA_W'($urandom);
      row_word[ROW_W-1:0] = first_row[ROW_W-1:0];
      csr_valid <= 1'b1;
      csr_index <= CSR_FIRST_ROW;
      csr_data  <= row_word;
      do @(posedge clock); while (!csr_ready);
      cfg_first_row = row_word[ROW_W-1:0];
      csr_index <= CSR_THRESHOLD;
      csr_data  <= threshold[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      cfg_threshold = threshold[THRESH_W-1:0];
      csr_valid <= 1'b0;
   endtask

   // frames of random length, mostly biased toward one kind of vote
   task automatic run_random_frames(int pixels);
      int sent;
      int len;
      int flavor;
      int angle;
      int row;
      sent = 0;
      while (sent < pixels) begin
         len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         flavor = $urandom_range(0, 4);
         for (int i = 0; i < len; i++) begin
            unique case (flavor)
               0: angle = $urandom_range(0, 1) ? $urandom_range(1, 89) : $urandom_range(271, 359);
               1: angle = $urandom_range(92, 270);
               2: angle = $urandom_range(90, 91);
               default: angle = $urandom_range(0, 360);
            endcase
            if ($urandom_range(0, 15) == 0) angle = 0;
            row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(cfg_first_row, 1023);
            send_pixel(angle, row, i == len - 1);
         end
         sent += len;
      end
   endtask

   task automatic test_directed_cases();
      send_pixel(0, 20, 0);      // no motion
      send_pixel(45, 14, 0);     // row above the region
      send_pixel(45, 15, 1);     // right
      send_pixel(90, 1023, 1);   // hold
      send_pixel(91, 15, 1);     // hold
      send_pixel(92, 100, 1);    // left clears the right count
      send_pixel(0, 200, 1);     // empty frame
      send_pixel(360, 16, 1);    // folds to zero, average zero
      send_pixel(271, 500, 0);
      send_pixel(359, 500, 1);   // folded 89 and 1
      send_pixel(270, 1023, 1);  // largest left average
      send_pixel(1, 0, 1);       // row zero skipped
      send_pixel(1, 15, 1);
      send_pixel(300, 40, 0);
      send_pixel(272, 40, 0);
      send_pixel(180, 40, 1);
      send_pixel(89, 511, 1);
      send_pixel(91, 512, 1);
      send_pixel(256, 768, 1);
      send_pixel(91, 20, 1);     // hold keeps left
      drain_results();
   endtask

   task automatic test_random_unlatched();
      load_config(0, VOTE_SAT);
      run_random_frames(110);
      drain_results();
      load_config(1023, VOTE_SAT);
      run_random_frames(40);
      drain_results();
      load_config($urandom_range(1, 60), $urandom_range(1000, 65534));
      run_random_frames(110);
      drain_results();
   endtask

   // result side held off long enough that the core stops taking pixels
   task automatic test_input_backpressure();
      set_idling(0);
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         begin
            for (int i = 0; i < 60; i++) begin
               send_pixel($urandom_range(1, 360), $urandom_range(cfg_first_row, 1023),
                          (i == 59) || ($urandom_range(0, 1) == 1));
            end
         end
      join
      drain_results();
      set_idling(1);
   endtask

   task automatic test_right_latch();
      load_config(5, 3);
      send_pixel(200, 600, 1);
      for (int i = 0; i < 5; i++) send_pixel($urandom_range(1, 89), $urandom_range(5, 1023), 1);
      for (int i = 0; i < 3; i++) send_pixel($urandom_range(92, 270), $urandom_range(5, 1023), 1);
      drain_results();
   endtask

   task automatic test_random_latched();
      load_config($urandom_range(0, 200), 0);
      run_random_frames(100);
      drain_results();
      load_config($urandom_range(0, 100), $urandom_range(0, 65535));
      run_random_frames(80);
      drain_results();
   endtask

   task automatic test_steady_stream();
      set_idling(0);
      load_config(15, 50);
      run_random_frames(60);
      drain_results();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      set_idling(1);
      test_directed_cases();
      test_random_unlatched();
      test_input_backpressure();
      test_right_latch();
      test_random_latched();
      test_steady_stream();
      drain_results();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("tb: failure");
      $finish;
   end

endmodule
